### sv/line_branch_coverage_table_assert.svh
// Assertion macros shared by the checker
`ifndef LINE_BRANCH_COVERAGE_TABLE_ASSERT_SVH
`define LINE_BRANCH_COVERAGE_TABLE_ASSERT_SVH
// clocked on clk, dropped while arst_n is low
`define LBC_ASSERT_IMP(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) else $error(msg);
`define LBC_ASSERT_NXT(label, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`endif

### sv/lbct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lbct_pkg;
	localparam int unsigned LinesDef = 4096;
	localparam int unsigned BranchEntriesDef = 256;
	localparam int unsigned ListLimitDef = 30;
	localparam logic [15:0] HitMax = 16'hFFFF;

	typedef enum logic [1:0] {
		ACT_REGISTER = 2'd0,
		ACT_RECORD   = 2'd1,
		ACT_BRANCH   = 2'd2,
		ACT_REPORT   = 2'd3
	} action_t;

	typedef enum logic [0:0] {
		KIND_SUMMARY   = 1'b0,
		KIND_UNCOVERED = 1'b1
	} kind_t;
endpackage
`default_nettype wire

### sv/lbct_branch_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Branch table: sequential search, append, and count of entries seen both ways.
module lbct_branch_table import lbct_pkg::*; #(
	parameter int unsigned BRANCH_ENTRIES = BranchEntriesDef,
	localparam int unsigned BW = (BRANCH_ENTRIES > 1) ? $clog2(BRANCH_ENTRIES) : 1,
	localparam int unsigned CW = $clog2(BRANCH_ENTRIES + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start_branch,
	input  wire logic          start_count,
	input  wire logic [15:0]   line,
	input  wire logic          taken,
	output logic               busy,
	output logic [CW-1:0]      count,
	output logic [CW-1:0]      covered
);
	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_RD   = 4'b0010,
		B_CHK  = 4'b0100,
		B_CNT  = 4'b1000
	} bstate_t;

	bstate_t state_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] cov_q;
	logic [15:0] line_q;
	logic taken_q;
	logic [17:0] mem [BRANCH_ENTRIES];
	logic [17:0] rd_q;
	logic [BW-1:0] ra;
	logic we;
	logic [BW-1:0] wa;
	logic [17:0] wd;

	assign busy = (state_q != B_IDLE);
	assign count = count_q;
	assign covered = cov_q;
	assign ra = idx_q[BW-1:0];

	always_comb begin
		we = 1'b0;
		wa = idx_q[BW-1:0];
		wd = rd_q;
		if (state_q == B_CHK) begin
			if (idx_q < count_q && rd_q[15:0] == line_q) begin
				we = 1'b1;
				wd = rd_q;
				if (taken_q) wd[16] = 1'b1;
				else wd[17] = 1'b1;
			end else if (idx_q >= count_q && count_q < CW'(BRANCH_ENTRIES)) begin
				we = 1'b1;
				wd = {!taken_q, taken_q, line_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			idx_q <= '0;
			count_q <= '0;
			cov_q <= '0;
			line_q <= '0;
			taken_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					idx_q <= '0;
					line_q <= line;
					taken_q <= taken;
					if (start_branch) begin
						state_q <= B_RD;
					end else if (start_count) begin
						cov_q <= '0;
						state_q <= (count_q == '0) ? B_IDLE : B_CNT;
					end
				end
				B_RD: begin
					state_q <= B_CHK;
				end
				B_CHK: begin
					if (idx_q >= count_q) begin
						if (count_q < CW'(BRANCH_ENTRIES)) count_q <= count_q + 1'b1;
						state_q <= B_IDLE;
					end else if (rd_q[15:0] == line_q) begin
						state_q <= B_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= B_RD;
					end
				end
				B_CNT: begin
					// read issued at idx, data returns next cycle, so the tally trails idx by one entry
					if (idx_q != '0 && rd_q[17] && rd_q[16]) cov_q <= cov_q + 1'b1;
					if (idx_q == count_q) state_q <= B_IDLE;
					else idx_q <= idx_q + 1'b1;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/line_branch_coverage_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Line and branch coverage collector.
// Input channel: in_valid/in_stall with action, line and taken. Output channel:
// out_valid/out_stall with one summary item, then uncovered line items.
// After reset the block sweeps the line memory to clear it, one entry a cycle,
// with in_stall high throughout.
// Register and record actions step through read, wait, write back through the
// line memory, then idle, before the next item is accepted. A line at or
// above LINES is dropped at once.
// A branch action searches the table one entry at a time, with a read and a
// check for each entry; the next item waits until the search ends.
// A report counts lines 1..highest_line one a cycle while the branch table counts
// its entries, sends the summary, then lists uncovered lines, reading one line
// and examining it before the next read.
// Results sit in an output register; a stall on the output holds the list walk
// until the item is taken. One item is in work at a time.
module line_branch_coverage_table import lbct_pkg::*; #(
	parameter int unsigned LINES = LinesDef,
	parameter int unsigned BRANCH_ENTRIES = BranchEntriesDef,
	parameter int unsigned LIST_LIMIT = ListLimitDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] line,
	input  wire logic        taken,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [12:0]      lines_hit,
	output logic [12:0]      lines_exec,
	output logic [8:0]       branches_both,
	output logic [8:0]       branches_known,
	output logic [11:0]      uncovered_line,
	output logic             truncated,
	output logic             last
);
	localparam int unsigned LW = $clog2(LINES);
	localparam int unsigned LCW = $clog2(LINES + 1);
	localparam int unsigned CW = $clog2(BRANCH_ENTRIES + 1);
	localparam int unsigned NW = $clog2(LIST_LIMIT + 1);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_LRD   = 9'b000000100,
		S_LWAIT = 9'b000001000,
		S_LWR   = 9'b000010000,
		S_BR    = 9'b000100000,
		S_CNT   = 9'b001000000,
		S_SUM   = 9'b010000000,
		S_LIST  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [LW-1:0] addr_q;
	logic [LCW-1:0] scan_q;
	logic [LW-1:0] top_q;
	logic [LW-1:0] highest_q;
	logic [LCW-1:0] tot_q, cov_q, unc_q;
	logic [NW-1:0] n_q;
	logic hit_q;
	logic [16:0] mem [LINES];
	logic [16:0] rd_q;
	logic rd_v_s1;
	logic [LW-1:0] rd_a_s1;
	logic mem_we;
	logic [LW-1:0] mem_wa, mem_ra;
	logic [16:0] mem_wd;
	logic br_busy;
	logic br_start_b, br_start_c;
	logic [CW-1:0] br_count, br_cov;
	logic in_acc, out_acc;
	logic ov_q;
	logic unc_hit, sum_load, list_load, rd_issue;

	lbct_branch_table #(.BRANCH_ENTRIES(BRANCH_ENTRIES)) u_br (
		.clk, .arst_n,
		.start_branch(br_start_b), .start_count(br_start_c),
		.line, .taken,
		.busy(br_busy), .count(br_count), .covered(br_cov)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = ov_q;
	assign out_acc = ov_q && !out_stall;
	assign br_start_b = in_acc && action == ACT_BRANCH;
	assign br_start_c = in_acc && action == ACT_REPORT;

	assign unc_hit = (state_q == S_LIST) && rd_v_s1 && rd_q[16] && rd_q[15:0] == '0;
	assign sum_load = (state_q == S_SUM) && !br_busy && (!ov_q || out_acc);
	assign list_load = unc_hit && (!ov_q || out_acc);
	// count pass reads back to back; list pass reads one line, examines it next cycle
	assign rd_issue = (state_q == S_CNT && scan_q <= LCW'(top_q))
		|| (state_q == S_LIST && !rd_v_s1);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		mem_ra = addr_q;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == S_LWR) begin
			mem_we = 1'b1;
			mem_wd = {1'b1, (hit_q && rd_q[15:0] != HitMax) ? rd_q[15:0] + 16'd1 : rd_q[15:0]};
		end else if (state_q == S_CNT || state_q == S_LIST) begin
			mem_ra = scan_q[LW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
		rd_a_s1 <= mem_ra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= rd_issue;
			if (sum_load || list_load) ov_q <= 1'b1;
			else if (out_acc) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q <= '0;
			scan_q <= '0;
			top_q <= '0;
			highest_q <= '0;
			tot_q <= '0;
			cov_q <= '0;
			unc_q <= '0;
			n_q <= '0;
			hit_q <= 1'b0;
			kind <= KIND_SUMMARY;
			lines_hit <= '0;
			lines_exec <= '0;
			branches_both <= '0;
			branches_known <= '0;
			uncovered_line <= '0;
			truncated <= 1'b0;
			last <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LW'(LINES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						addr_q <= line[LW-1:0];
						hit_q <= (action == ACT_RECORD);
						case (action)
							ACT_REGISTER, ACT_RECORD: begin
								if (32'(line) < LINES) begin
									state_q <= S_LRD;
									if (32'(line) > 32'(highest_q)) highest_q <= line[LW-1:0];
								end
							end
							ACT_BRANCH: state_q <= S_BR;
							default: begin
								scan_q <= LCW'(1);
								top_q <= highest_q;
								tot_q <= '0;
								cov_q <= '0;
								unc_q <= '0;
								state_q <= S_CNT;
							end
						endcase
					end
				end
				S_LRD: state_q <= S_LWAIT;
				S_LWAIT: state_q <= S_LWR;
				S_LWR: state_q <= S_IDLE;
				S_BR: if (!br_busy) state_q <= S_IDLE;
				S_CNT: begin
					// issue reads for 1..top, tally each line in the cycle after its read
					if (rd_issue) scan_q <= scan_q + 1'b1;
					if (rd_v_s1 && rd_q[16]) begin
						tot_q <= tot_q + 1'b1;
						if (rd_q[15:0] != '0) cov_q <= cov_q + 1'b1;
						else unc_q <= unc_q + 1'b1;
					end
					if (!rd_issue && !rd_v_s1) state_q <= S_SUM;
				end
				S_SUM: begin
					if (sum_load) begin
						kind <= KIND_SUMMARY;
						lines_hit <= 13'(cov_q);
						lines_exec <= (tot_q == '0) ? 13'd1 : 13'(tot_q);
						branches_both <= 9'(br_cov);
						branches_known <= 9'(br_count);
						uncovered_line <= '0;
						truncated <= 1'b0;
						last <= (unc_q == '0);
						scan_q <= LCW'(1);
						n_q <= NW'(1);
						state_q <= (unc_q == '0) ? S_IDLE : S_LIST;
					end
				end
				S_LIST: begin
					// one read in flight at a time; a hit waits for the output slot
					if (list_load) begin
						kind <= KIND_UNCOVERED;
						lines_hit <= '0;
						lines_exec <= '0;
						branches_both <= '0;
						branches_known <= '0;
						uncovered_line <= 12'(rd_a_s1);
						truncated <= (n_q == NW'(LIST_LIMIT));
						last <= (n_q == NW'(LIST_LIMIT)) || (LCW'(n_q) == unc_q);
						n_q <= n_q + 1'b1;
						if ((n_q == NW'(LIST_LIMIT)) || (LCW'(n_q) == unc_q))
							state_q <= S_IDLE;
					end else if (unc_hit) begin
						// slot still full: step back and read the same line again
						scan_q <= LCW'(rd_a_s1);
					end else if (rd_issue) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/lbct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "line_branch_coverage_table_assert.svh"
module lbct_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        kind,
	input wire logic [12:0] lines_exec,
	input wire logic [12:0] lines_hit,
	input wire logic [11:0] uncovered_line,
	input wire logic        last
);
	logic out_held;
	assign out_held = out_valid && out_stall;

	`LBC_ASSERT_NXT(a_out_hold, out_held, out_valid && $stable(uncovered_line), "stall moved item")
	`LBC_ASSERT_IMP(a_sum_exec, out_valid && !kind, lines_exec != 13'd0, "zero line total")
	`LBC_ASSERT_IMP(a_sum_hit, out_valid && !kind, lines_hit <= lines_exec, "hits over total")
	`LBC_ASSERT_IMP(a_unc_line, out_valid && kind, uncovered_line != 12'd0, "line zero listed")
	`LBC_ASSERT_IMP(a_busy_out, out_valid && !last, in_stall, "input taken mid report")
endmodule
bind line_branch_coverage_table lbct_checker u_chk (
	.clk, .arst_n, .in_stall, .out_valid, .out_stall, .kind,
	.lines_exec, .lines_hit, .uncovered_line, .last
);
`default_nettype wire

### test/tb_line_branch_coverage_table.sv
`timescale 1ns / 1ps
module tb_line_branch_coverage_table;
	import lbct_pkg::*;

	localparam int NLINES = LinesDef;
	localparam int NBR = BranchEntriesDef;
	localparam int NLIST = ListLimitDef;
	localparam int WATCH_LIMIT = 40000;

	typedef struct packed {
		logic [1:0]  act;
		logic [15:0] ln;
		logic        tk;
	} event_t;

	typedef struct packed {
		logic        kind;
		logic [12:0] cl;
		logic [12:0] tl;
		logic [8:0]  cb;
		logic [8:0]  tb;
		logic [11:0] ul;
		logic        tr;
		logic        lst;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_REGISTER;
	logic [15:0] line = '0;
	logic taken = 1'b0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic kind;
	logic [12:0] lines_hit, lines_exec;
	logic [8:0] branches_both, branches_known;
	logic [11:0] uncovered_line;
	logic truncated, last;

	line_branch_coverage_table u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .line(line), .taken(taken),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .lines_hit(lines_hit), .lines_exec(lines_exec),
		.branches_both(branches_both), .branches_known(branches_known),
		.uncovered_line(uncovered_line), .truncated(truncated), .last(last)
	);

	// predictor state
	bit          p_exec [NLINES];
	logic [15:0] p_hits [NLINES];
	int          p_high;
	logic [15:0] p_bline [NBR];
	bit          p_btk [NBR];
	bit          p_bnt [NBR];
	int          p_bcount;

	event_t  pending_events [$];
	report_t expected_reports [$];
	int errors = 0;
	bit hold_sender = 0;

	initial forever #1 clk = ~clk;

	function automatic void tally_event(event_t e);
		int i;
		int tot, cov, unc, cbr, n;
		report_t r;
		bit found;
		case (e.act)
			ACT_REGISTER, ACT_RECORD: begin
				if (e.ln < NLINES) begin
					p_exec[e.ln] = 1;
					if (e.act == ACT_RECORD && p_hits[e.ln] != HitMax)
						p_hits[e.ln] = p_hits[e.ln] + 16'd1;
					if (e.ln > p_high)
						p_high = e.ln;
				end
			end
			ACT_BRANCH: begin
				found = 0;
				for (i = 0; i < p_bcount && !found; i++) begin
					if (p_bline[i] == e.ln) begin
						if (e.tk)
							p_btk[i] = 1;
						else
							p_bnt[i] = 1;
						found = 1;
					end
				end
				if (!found && p_bcount < NBR) begin
					p_bline[p_bcount] = e.ln;
					p_btk[p_bcount] = e.tk;
					p_bnt[p_bcount] = !e.tk;
					p_bcount++;
				end
			end
			default: begin
				tot = 0; cov = 0; unc = 0; cbr = 0;
				for (i = 1; i <= p_high; i++) begin
					if (p_exec[i]) begin
						tot++;
						if (p_hits[i] != 0)
							cov++;
						else
							unc++;
					end
				end
				if (tot == 0)
					tot = 1;
				for (i = 0; i < p_bcount; i++)
					if (p_btk[i] && p_bnt[i])
						cbr++;
				r = '0;
				r.kind = KIND_SUMMARY;
				r.cl = 13'(cov); r.tl = 13'(tot); r.cb = 9'(cbr); r.tb = 9'(p_bcount);
				r.lst = (unc == 0);
				expected_reports.push_back(r);
				n = 1;
				for (i = 1; i <= p_high && unc != 0; i++) begin
					if (p_exec[i] && p_hits[i] == 0) begin
						r = '0;
						r.kind = KIND_UNCOVERED;
						r.ul = 12'(i);
						r.tr = (n == NLIST);
						r.lst = r.tr || (n == unc);
						expected_reports.push_back(r);
						n++;
						if (r.lst)
							break;
					end
				end
			end
		endcase
	endfunction

	// driver
	int in_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tally_event(pending_events.pop_front());
				in_gap = $urandom_range(0, 13);
				if ($urandom_range(0, 3) == 0)
					in_gap = 0;
			end
			if ((!in_valid || !in_stall) ) begin
				if (in_valid && !in_stall && (in_gap != 0 || pending_events.size() == 0
						|| hold_sender))
					in_valid <= 1'b0;
				else if (!in_valid && in_gap != 0)
					in_gap--;
				if (in_gap == 0 && pending_events.size() != 0 && !hold_sender) begin
					in_valid <= 1'b1;
					action <= pending_events[0].act;
					line <= pending_events[0].ln;
					taken <= pending_events[0].tk;
				end
			end
		end
	end

	// monitor
	int out_gap = 0;
	report_t got;
	report_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {kind, lines_hit, lines_exec, branches_both, branches_known,
					uncovered_line, truncated, last};
				if (expected_reports.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %h actual %h", want, got);
					end
				end
				out_gap = $urandom_range(0, 13);
				if ($urandom_range(0, 3) == 0)
					out_gap = 0;
			end
			if (out_gap != 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// watchdog
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("tb_line_branch_coverage_table: errors");
			$finish;
		end
	end

	function automatic event_t mk(logic [1:0] a, logic [15:0] l, logic t);
		event_t e;
		e.act = a; e.ln = l; e.tk = t;
		return e;
	endfunction

	// small lines mostly, so reports stay short
	function automatic logic [15:0] pick_line();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 16'hFFFF));
			1: return 16'($urandom_range(NLINES - 8, NLINES - 1));
			default: return 16'($urandom_range(0, 60));
		endcase
	endfunction

	task automatic drain();
		wait (pending_events.size() == 0 && !in_valid && expected_reports.size() == 0);
	endtask

	int k;
	logic [1:0] a;
	initial begin
		for (k = 0; k < NLINES; k++) begin
			p_exec[k] = 0; p_hits[k] = 0;
		end
		p_high = 0; p_bcount = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty report, line zero, extremes, out of range, branches
		pending_events.push_back(mk(ACT_REPORT, 16'd0, 1'b0));
		pending_events.push_back(mk(ACT_RECORD, 16'd0, 1'b1));
		pending_events.push_back(mk(ACT_REGISTER, 16'd0, 1'b0));
		pending_events.push_back(mk(ACT_REPORT, 16'hFFFF, 1'b1));
		pending_events.push_back(mk(ACT_REGISTER, 16'(NLINES), 1'b0));
		pending_events.push_back(mk(ACT_RECORD, 16'hFFFF, 1'b1));
		pending_events.push_back(mk(ACT_REGISTER, 16'd1, 1'b0));
		pending_events.push_back(mk(ACT_RECORD, 16'(NLINES - 1), 1'b0));
		pending_events.push_back(mk(ACT_BRANCH, 16'hFFFF, 1'b1));
		pending_events.push_back(mk(ACT_BRANCH, 16'hFFFF, 1'b0));
		pending_events.push_back(mk(ACT_BRANCH, 16'd0, 1'b0));
		pending_events.push_back(mk(ACT_BRANCH, 16'h5555, 1'b1));
		pending_events.push_back(mk(ACT_REPORT, 16'hAAAA, 1'b0));
		for (k = 2; k < 36; k += 2)
			pending_events.push_back(mk(ACT_REGISTER, 16'(k), 1'b0));
		pending_events.push_back(mk(ACT_REPORT, 16'd0, 1'b0));
		drain();
		hold_sender = 1;
		repeat (20) @(posedge clk);
		hold_sender = 0;

		// random body
		for (k = 0; k < 130; k++) begin
			a = ($urandom_range(0, 9) == 0) ? ACT_REPORT : 2'($urandom_range(0, 2));
			pending_events.push_back(mk(a, pick_line(), 1'($urandom_range(0, 1))));
		end
		pending_events.push_back(mk(ACT_REPORT, 16'd0, 1'b0));
		drain();

		// fill the branch table past its end
		for (k = 0; k < NBR + 4; k++)
			pending_events.push_back(mk(ACT_BRANCH, 16'(16'h8000 + k), k[0]));
		pending_events.push_back(mk(ACT_REPORT, 16'd0, 1'b0));
		drain();
		repeat (2 * NLINES + 3 * NBR + 100) @(posedge clk);
		if (errors == 0 && expected_reports.size() == 0)
			$display("tb_line_branch_coverage_table: clean");
		else
			$display("tb_line_branch_coverage_table: errors");
		$finish;
	end
endmodule

### line_branch_coverage_table.f
+incdir+sv
sv/lbct_pkg.sv
sv/lbct_branch_table.sv
sv/line_branch_coverage_table.sv
sv/lbct_checker.sv
test/tb_line_branch_coverage_table.sv
